>>> rtl/six_axis_moving_average_unit_defines.svh
// ----------------------------------------------------------------------------
// six_axis_moving_average_unit_defines
// assertion macros used by the moving-average top level
// ----------------------------------------------------------------------------
`ifndef SIX_AXIS_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define SIX_AXIS_MOVING_AVERAGE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every rising clock edge outside reset
`define SAMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sama assertion failed");
// checked on every rising clock edge, reset included
`define SAMA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sama assertion failed");
`else
`define SAMA_ASSERT(lbl, prop)
`define SAMA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/sama_pkg.sv
// ----------------------------------------------------------------------------
// sama_pkg
// shared types and constants of the six-axis moving average
// ----------------------------------------------------------------------------
`default_nettype none

package sama_pkg;

  localparam int unsigned AXES      = 6;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GYRO_BASE = 3;
  localparam int unsigned NUM_GYRO  = 3;
  localparam int unsigned ROW_W     = AXES * SAMPLE_W;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_X_OFFSET = 2'd0,
    CFG_GYRO_Y_OFFSET = 2'd1,
    CFG_GYRO_Z_OFFSET = 2'd2
  } sama_cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } sama_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg_accel_x;
    logic signed [SAMPLE_W-1:0] avg_accel_y;
    logic signed [SAMPLE_W-1:0] avg_accel_z;
    logic signed [SAMPLE_W-1:0] avg_gyro_x;
    logic signed [SAMPLE_W-1:0] avg_gyro_y;
    logic signed [SAMPLE_W-1:0] avg_gyro_z;
  } sama_out_t;

  // stage enables of the divider lanes
  typedef struct packed {
    logic mul_en;
    logic fix_en;
  } sama_div_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sama_sample_ram.sv
// ----------------------------------------------------------------------------
// sama_sample_ram
// ring storage of all six axes, one row per ring slot, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module sama_sample_ram #(
  parameter int unsigned Depth = 10,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [AddrW-1:0]           rd_addr_i,
  output logic [sama_pkg::ROW_W-1:0]      rd_data_o,
  input  wire logic                       wr_en_i,
  input  wire logic [AddrW-1:0]           wr_addr_i,
  input  wire logic [sama_pkg::ROW_W-1:0] wr_data_i
);
  import sama_pkg::*;

  logic [ROW_W-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [ROW_W-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // rows never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> rtl/sama_div.sv
// ----------------------------------------------------------------------------
// sama_div
// signed divide of one running sum by the window, truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module sama_div #(
  parameter int unsigned WINDOW = 10,
  localparam int unsigned SumW = sama_pkg::SAMPLE_W + $clog2(WINDOW)
) (
  input  wire logic                              clk_i,
  input  wire sama_pkg::sama_div_ctl_t           ctl_i,
  input  wire logic signed [SumW-1:0]            sum_i,
  output logic signed [sama_pkg::SAMPLE_W-1:0]   avg_o
);
  import sama_pkg::*;

  localparam int unsigned MagW   = SumW;
  localparam int unsigned RecipW = SumW + 1;
  localparam int unsigned ProdW  = MagW + RecipW;
  // floor(2^SumW / WINDOW): quotient estimate is low by at most one
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << SumW) / 64'(WINDOW));
  localparam logic [MagW-1:0]   WinM  = MagW'(WINDOW);

  logic [MagW-1:0]  mag;
  logic [ProdW-1:0] prod;
  logic             neg_q;
  logic [MagW-1:0]  mag_q;
  logic [MagW-1:0]  q0_q;
  logic [MagW-1:0]  q0w;
  logic [MagW-1:0]  rem;
  logic [MagW-1:0]  qmag_q;
  logic [SAMPLE_W-1:0] qlow;

  assign mag  = sum_i[SumW-1] ? MagW'(-sum_i) : MagW'(sum_i);
  assign prod = ProdW'(mag) * ProdW'(Recip);

  // low-by-one correction from the remainder
  assign q0w = MagW'(q0_q * WinM);
  assign rem = mag_q - q0w;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      neg_q <= sum_i[SumW-1];
      mag_q <= mag;
      q0_q  <= MagW'(prod >> SumW);
    end
    if (ctl_i.fix_en) begin
      qmag_q <= (rem >= WinM) ? MagW'(q0_q + MagW'(1)) : q0_q;
    end
  end

  assign qlow  = qmag_q[SAMPLE_W-1:0];
  assign avg_o = neg_q ? SAMPLE_W'(-qlow) : qlow;

endmodule

`default_nettype wire

>>> rtl/six_axis_moving_average_unit.sv
// ----------------------------------------------------------------------------
// six_axis_moving_average_unit
// windowed average of six inertial axes with gyro offset removal
//
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   in_data_i   (sama_in_t)
// out      output     out_valid_o/out_ready_i out_data_o  (sama_out_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// each request runs from acceptance through one sample-memory read, the
// read-modify-write of the running sums and two reciprocal-divider stages,
// all run by one sequencer, before the next request is taken. a new request
// is taken while the previous result still waits
// in the output register; a stalled output holds the sequencer in its last
// stage. reset clears the ring through per-row valid bits at once, so no
// clearing pass is needed. configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "six_axis_moving_average_unit_defines.svh"

module six_axis_moving_average_unit #(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire sama_pkg::sama_in_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output sama_pkg::sama_out_t                     out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sama_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic signed [sama_pkg::SAMPLE_W-1:0] cfg_data_i
);
  import sama_pkg::*;

  localparam int unsigned PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW = SAMPLE_W + $clog2(WINDOW);

  // sequencer, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_OUT  = 5'b10000
  } sama_state_e;

  sama_state_e state_q, state_d;

  logic [PosW-1:0]            pos_q, pos_d;
  sama_in_t                   in_q;
  logic signed [SAMPLE_W-1:0] offs_q [NUM_GYRO];
  logic signed [SumW-1:0]     sum_q [AXES];
  logic signed [SumW-1:0]     sum_d [AXES];
  logic signed [SAMPLE_W-1:0] new_smp [AXES];
  logic signed [SAMPLE_W-1:0] old_smp [AXES];
  logic signed [SAMPLE_W-1:0] avg [AXES];
  logic signed [SAMPLE_W-1:0] res [AXES];
  logic [ROW_W-1:0]           rd_row;
  logic [ROW_W-1:0]           wr_row;
  logic                       accept;
  logic                       sum_en;
  logic                       load_out;
  logic                       out_valid_q;
  sama_out_t                  out_q;
  sama_div_ctl_t              div_ctl;

  // ---------------------------------------------------------------- handshakes
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign sum_en      = (state_q == ST_RD);
  // result moves on when the output register is empty or draining
  assign load_out    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  assign div_ctl.mul_en = (state_q == ST_MUL);
  assign div_ctl.fix_en = (state_q == ST_FIX);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD;
        end
      end
      ST_RD:   state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIX;
      ST_FIX:  state_d = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // shared ring slot, wraps at the end of the window
  assign pos_d = (pos_q == PosW'(WINDOW - 1)) ? '0 : PosW'(pos_q + PosW'(1));

  // ---------------------------------------------------------------- sample ring
  assign new_smp[0] = in_q.accel_x;
  assign new_smp[1] = in_q.accel_y;
  assign new_smp[2] = in_q.accel_z;
  assign new_smp[3] = in_q.gyro_x;
  assign new_smp[4] = in_q.gyro_y;
  assign new_smp[5] = in_q.gyro_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      wr_row[a*SAMPLE_W +: SAMPLE_W] = new_smp[a];
      old_smp[a] = rd_row[a*SAMPLE_W +: SAMPLE_W];
      // running sum: add the incoming sample, drop the one it replaces
      sum_d[a] = sum_q[a] + SumW'(new_smp[a]) - SumW'(old_smp[a]);
    end
  end

  sama_sample_ram #(
    .Depth (WINDOW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (pos_q),
    .rd_data_o (rd_row),
    .wr_en_i   (sum_en),
    .wr_addr_i (pos_q),
    .wr_data_i (wr_row)
  );

  // ---------------------------------------------------------------- dividers
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    sama_div #(
      .WINDOW (WINDOW)
    ) u_div (
      .clk_i (clk_i),
      .ctl_i (div_ctl),
      .sum_i (sum_q[a]),
      .avg_o (avg[a])
    );
  end

  // gyro offsets wrap to 16 bits, accel averages pass through
  always_comb begin
    for (int a = 0; a < GYRO_BASE; a++) begin
      res[a] = avg[a];
    end
    for (int g = 0; g < NUM_GYRO; g++) begin
      res[GYRO_BASE + g] = SAMPLE_W'(avg[GYRO_BASE + g] - offs_q[g]);
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
      for (int g = 0; g < NUM_GYRO; g++) begin
        offs_q[g] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (sum_en) begin
        pos_q <= pos_d;
        for (int a = 0; a < AXES; a++) begin
          sum_q[a] <= sum_d[a];
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GYRO_X_OFFSET: offs_q[0] <= cfg_data_i;
          CFG_GYRO_Y_OFFSET: offs_q[1] <= cfg_data_i;
          CFG_GYRO_Z_OFFSET: offs_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (load_out) begin
      out_q.avg_accel_x <= res[0];
      out_q.avg_accel_y <= res[1];
      out_q.avg_accel_z <= res[2];
      out_q.avg_gyro_x  <= res[3];
      out_q.avg_gyro_y  <= res[4];
      out_q.avg_gyro_z  <= res[5];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  `SAMA_ASSERT(a_accept_to_rmw, accept |=> (state_q == ST_RD))
  `SAMA_ASSERT(a_rmw_same_slot, (state_q == ST_RD) |-> (pos_q == $past(pos_q)))
  `SAMA_ASSERT(a_load_shows, load_out |=> out_valid_o)
  `SAMA_ASSERT(a_pos_in_window, pos_q <= PosW'(WINDOW - 1))

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the six-axis moving average against a window model of its own:
// requests go through a random-gap driver, results are taken by a randomly
// stalling receiver and compared field by field with the predicted averages
// ----------------------------------------------------------------------------
module testbench;
  import sama_pkg::*;

  localparam int unsigned WINDOW          = 10;
  // the one index the block has no register for
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  // settling time once every request is answered
  localparam int unsigned SETTLE_CYCLES   = 12;

  // clock, reset and the three channels
  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  sama_in_t                   in_data   = '0;
  logic                       out_ready = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic signed [SAMPLE_W-1:0] cfg_data  = '0;
  wire logic                  in_ready;
  wire logic                  out_valid;
  wire logic                  cfg_ready;
  sama_out_t                  out_data;

  // request source and expected averages
  sama_in_t    pending_q [$];
  sama_out_t   expected_avg_q [$];
  int unsigned requests_queued = 0;
  int unsigned requests_taken  = 0;
  int          errors          = 0;

  // window model: one ring per axis, shared slot, gyro offsets
  logic signed [SAMPLE_W-1:0] ring_mem [AXES][WINDOW];
  int unsigned                slot;
  logic signed [SAMPLE_W-1:0] offset_mirror [NUM_GYRO];

  // handshake bookkeeping for the negedge processes
  logic        in_taken = 1'b0;
  int unsigned in_gap   = 0;
  int unsigned out_gap  = 0;
  bit          idle_on  = 1'b1;

  six_axis_moving_average_unit #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic string axis_label(input int unsigned a);
    case (a)
      0: return "avg_accel_x";
      1: return "avg_accel_y";
      2: return "avg_accel_z";
      3: return "avg_gyro_x";
      4: return "avg_gyro_y";
      default: return "avg_gyro_z";
    endcase
  endfunction

  // write one sample into the rings, then average every ring
  task automatic push_sample_and_average(input sama_in_t s, output sama_out_t avg);
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] res;
    int               sum;
    int               mean;
    row = s;
    for (int unsigned a = 0; a < AXES; a++) begin
      ring_mem[a][slot] = row[ROW_W-1-a*SAMPLE_W -: SAMPLE_W];
    end
    slot = (slot == WINDOW - 1) ? 0 : slot + 1;
    for (int unsigned a = 0; a < AXES; a++) begin
      sum = 0;
      for (int unsigned i = 0; i < WINDOW; i++) begin
        sum += ring_mem[a][i];
      end
      // signed division truncates toward zero
      mean = sum / int'(WINDOW);
      // gyro offset removal wraps, no saturation
      if (a >= GYRO_BASE) begin
        mean = mean - offset_mirror[a-GYRO_BASE];
      end
      res[ROW_W-1-a*SAMPLE_W -: SAMPLE_W] = mean[SAMPLE_W-1:0];
    end
    avg = res;
  endtask

  // monitor: everything is sampled at the rising edge
  always @(posedge clk) begin
    sama_out_t   want;
    logic [ROW_W-1:0] want_row;
    logic [ROW_W-1:0] got_row;
    if (!rst_n) begin
      for (int unsigned a = 0; a < AXES; a++) begin
        for (int unsigned i = 0; i < WINDOW; i++) begin
          ring_mem[a][i] = '0;
        end
      end
      slot = 0;
      for (int unsigned g = 0; g < NUM_GYRO; g++) begin
        offset_mirror[g] = '0;
      end
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      // index 3 has no register behind it and is dropped
      if (cfg_valid && cfg_ready && cfg_index != CFG_UNMAPPED) begin
        offset_mirror[cfg_index] = cfg_data;
      end
      // check the oldest expectation before adding a new one
      if (out_valid && out_ready) begin
        if (expected_avg_q.size() == 0) begin
          $display("%0t ns: result %h arrived with no request pending", $time, out_data);
          errors++;
        end else begin
          want     = expected_avg_q.pop_front();
          want_row = want;
          got_row  = out_data;
          for (int unsigned a = 0; a < AXES; a++) begin
            if (want_row[ROW_W-1-a*SAMPLE_W -: SAMPLE_W] !==
                got_row[ROW_W-1-a*SAMPLE_W -: SAMPLE_W]) begin
              $display("%0t ns: %s expected %0d actual %0d", $time, axis_label(a),
                       $signed(want_row[ROW_W-1-a*SAMPLE_W -: SAMPLE_W]),
                       $signed(got_row[ROW_W-1-a*SAMPLE_W -: SAMPLE_W]));
              errors++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        push_sample_and_average(in_data, want);
        expected_avg_q.push_back(want);
        requests_taken++;
      end
    end
  end

  // request driver: changes at the falling edge, holds until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        // idle burst: in_gap holds the idle cycles left after this one
        in_gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stalls in random bursts, counted down in out_gap
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_request(input sama_in_t s);
    pending_q.push_back(s);
    requests_queued++;
  endtask

  // same reading on all six axes
  function automatic sama_in_t uniform_sample(input logic [SAMPLE_W-1:0] v);
    return {AXES{v}};
  endfunction

  // extremes, values near zero or anything at all
  function automatic logic [SAMPLE_W-1:0] random_reading(input int unsigned mode);
    logic [SAMPLE_W-1:0] v;
    case (mode)
      0: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: begin
        v = 16'($urandom_range(0, 63));
        v = v - 16'd32;
      end
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  function automatic sama_in_t random_sample(input int unsigned mode);
    logic [ROW_W-1:0] row;
    for (int unsigned a = 0; a < AXES; a++) begin
      row[ROW_W-1-a*SAMPLE_W -: SAMPLE_W] = random_reading(mode);
    end
    return row;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_offset();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // config write on its own channel, valid held until taken
  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx,
                              input logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all requests accepted and answered, then let the pipeline settle
  task automatic wait_until_idle();
    while (requests_taken != requests_queued || expected_avg_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    sama_in_t    s;
    int unsigned n;
    int unsigned pick;

    // reset once, released at a falling edge
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // warm-up at reset offsets: zeros, then a ramp of full-scale positive,
    // then full-scale negative so truncation toward zero shows on odd sums
    queue_request(uniform_sample(16'h0000));
    repeat (9) queue_request(uniform_sample(16'h7fff));
    repeat (10) queue_request(uniform_sample(16'h8000));
    wait_until_idle();

    // offset extremes make the gyro subtraction wrap both ways
    write_offset(CFG_GYRO_X_OFFSET, 16'h8000);
    write_offset(CFG_GYRO_Y_OFFSET, 16'h7fff);
    write_offset(CFG_GYRO_Z_OFFSET, 16'hffff);
    // write to the missing register must leave the offsets alone
    write_offset(CFG_UNMAPPED, 16'h1234);
    queue_request(uniform_sample(16'h7fff));
    queue_request(uniform_sample(16'h7fff));
    queue_request(uniform_sample(16'h8000));
    queue_request(uniform_sample(16'h0000));
    queue_request('{accel_x: 16'sh7fff, accel_y: 16'sh8000, accel_z: 16'sh0001,
                    gyro_x: 16'sh8000, gyro_y: 16'sh7fff, gyro_z: 16'shffff});

    // random phases, new offsets each time, no idling in the last one
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_until_idle();
      idle_on = (p != RANDOM_PHASES - 1);
      write_offset(CFG_GYRO_X_OFFSET, random_offset());
      write_offset(CFG_GYRO_Y_OFFSET, random_offset());
      write_offset(CFG_GYRO_Z_OFFSET, random_offset());
      if ($urandom_range(0, 2) == 0) begin
        write_offset(CFG_UNMAPPED, 16'($urandom()));
      end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // steady input for a whole window
          s = random_sample($urandom_range(0, 2));
          repeat (WINDOW) queue_request(s);
          n += WINDOW;
        end else begin
          queue_request(random_sample(pick == 1 ? 0 : (pick == 2 ? 1 : 2)));
          n++;
        end
      end
    end

    wait_until_idle();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sama_pkg.sv
rtl/sama_sample_ram.sv
rtl/sama_div.sv
rtl/six_axis_moving_average_unit.sv
tb/testbench.sv
